// ===== sv/small_matrix_multiply_macros.svh =====
`ifndef SMALL_MATRIX_MULTIPLY_MACROS_SVH
`define SMALL_MATRIX_MULTIPLY_MACROS_SVH

// Assertion helpers for the matrix multiply block, clocked on clk and off during rst.
`define SMM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/smm_pkg.sv =====
`default_nettype none

package smm_pkg;

  localparam int MAX_DIM = 8;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ROW_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 4;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = PROD_W + ROW_W;
  localparam int IDX_W   = 6;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] REG_NUM_ROWS  = 2'd0;
  localparam logic [1:0] REG_INNER_LEN = 2'd1;
  localparam logic [1:0] REG_NUM_COLS  = 2'd2;
  localparam logic [1:0] REG_ELEMWISE  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last_term;
    logic              run_last;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] col;
  } term_tag_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols;
    logic             elementwise;
  } dims_t;

endpackage

`default_nettype wire

// ===== sv/small_matrix_multiply.sv =====
// Small signed fixed-point matrix multiply with one shared multiply-accumulate.
// Input stream s_*: one word per item. s_tuser carries the command (write A entry,
// write B entry, compute). A write stores a Q8.8 value at a flat row-major index.
// A compute word starts a run over the result entries.
// Output stream m_*: one word per result entry in row-major order, Q16.16
// saturated to 32 bits, with m_tlast on the final entry of a run.
// A matrix run issues one product per cycle through the single multiplier while the output
// is not stalled, rows*inner*cols products in all (rows*cols in elementwise mode); the last
// entry appears once its product has been read, multiplied and accumulated.
// s_tready stays low from the compute word until the multiplier pipeline is empty.
// The config channel writes num_rows, inner_len, num_cols and elementwise_mode;
// it is always ready and must only be used while no run is in progress.
// Reset sets all three dimensions to 1 and selects the matrix product; the
// element stores are not cleared and hold unknown data until written.
// When the receiver holds m_tready low, the waiting word stays in the output
// register and the whole multiply pipeline and sequencer freeze until it is taken.
`default_nettype none

module small_matrix_multiply (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // index[5:0], value[21:6], zero pad
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // product_value[31:0], out_row[34:32],
                                      // out_col[40:35], zero pad
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import smm_pkg::*;

  `include "small_matrix_multiply_macros.svh"

  dims_t              dims;
  logic               s_accept;
  logic [CMD_W-1:0]   command;
  logic [IDX_W-1:0]   index;
  logic [VAL_W-1:0]   value;
  logic               adv;
  logic               start;
  logic               seq_active;
  logic [ADDR_W-1:0]  a_addr;
  logic [ADDR_W-1:0]  b_addr;
  term_tag_t          tag;
  logic [VAL_W-1:0]   a_rd;
  logic [VAL_W-1:0]   b_rd;
  logic               pipe_busy;
  logic [PROD_W-1:0]  out_value;
  logic [ROW_W-1:0]   out_row;
  logic [ADDR_W-1:0]  out_col;
  logic               load_ok;

  assign command   = s_tuser;
  assign index     = s_tdata[IDX_W-1:0];
  assign value     = s_tdata[IDX_W+VAL_W-1:IDX_W];
  assign s_tready  = !seq_active && !pipe_busy;
  assign s_accept  = s_tvalid && s_tready;
  assign start     = s_accept && (command == CMD_COMPUTE);
  assign load_ok   = ({1'b0, index} < (IDX_W+1)'(DEPTH));
  assign adv       = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'b0, out_col, out_row, out_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.rows        <= DIM_W'(1);
      dims.inner       <= DIM_W'(1);
      dims.cols        <= DIM_W'(1);
      dims.elementwise <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_ROWS:  dims.rows        <= cfg_data;
        REG_INNER_LEN: dims.inner       <= cfg_data;
        REG_NUM_COLS:  dims.cols        <= cfg_data;
        REG_ELEMWISE:  dims.elementwise <= cfg_data[0];
        default:       dims.rows        <= dims.rows;
      endcase
    end
  end

  smm_store u_store_a (
    .clk   (clk),
    .we    (s_accept && (command == CMD_WRITE_A) && load_ok),
    .waddr (ADDR_W'(index)),
    .wdata (value),
    .re    (adv),
    .raddr (a_addr),
    .rdata (a_rd)
  );

  smm_store u_store_b (
    .clk   (clk),
    .we    (s_accept && (command == CMD_WRITE_B) && load_ok),
    .waddr (ADDR_W'(index)),
    .wdata (value),
    .re    (adv),
    .raddr (b_addr),
    .rdata (b_rd)
  );

  smm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .dims   (dims),
    .adv    (adv),
    .active (seq_active),
    .a_addr (a_addr),
    .b_addr (b_addr),
    .tag    (tag)
  );

  smm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tag_in    (tag),
    .a_rd      (a_rd),
    .b_rd      (b_rd),
    .pipe_busy (pipe_busy),
    .out_valid (m_tvalid),
    .out_value (out_value),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (m_tlast)
  );

  `SMM_ASSERT_NEXT(a_compute_busy, start, !s_tready, "compute word did not make the block busy")
  `SMM_ASSERT_NEXT(a_stall_freeze, m_tvalid && !m_tready && seq_active,
                   $stable(a_addr) && $stable(b_addr), "sequencer moved during output stall")
  `SMM_ASSERT_IMPLY(a_out_from_pipe, $rose(m_tvalid), $past(pipe_busy),
                    "result word appeared with an empty multiply pipeline")

endmodule

`default_nettype wire

// ===== sv/smm_store.sv =====
`default_nettype none

module smm_store (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [smm_pkg::ADDR_W-1:0]  waddr,
  input  wire logic [smm_pkg::VAL_W-1:0]   wdata,
  input  wire logic                        re,
  input  wire logic [smm_pkg::ADDR_W-1:0]  raddr,
  output logic      [smm_pkg::VAL_W-1:0]   rdata
);
  import smm_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/smm_seq.sv =====
`default_nettype none

module smm_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire smm_pkg::dims_t              dims,
  input  wire logic                        adv,
  output logic                             active,
  output logic      [smm_pkg::ADDR_W-1:0]  a_addr,
  output logic      [smm_pkg::ADDR_W-1:0]  b_addr,
  output smm_pkg::term_tag_t               tag
);
  import smm_pkg::*;

  logic [DIM_W-1:0]  rows;
  logic [DIM_W-1:0]  inner;
  logic [DIM_W-1:0]  cols;
  logic              ew;
  logic [ROW_W-1:0]  i;
  logic [ROW_W-1:0]  j;
  logic [ROW_W-1:0]  k;
  logic [ADDR_W-1:0] row_base;
  logic              last_term;
  logic              last_col;
  logic              last_row;
  logic [ADDR_W-1:0] row_base_next;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign last_term     = ew || (k == ROW_W'(inner - DIM_W'(1)));
  assign last_col      = (j == ROW_W'(cols - DIM_W'(1)));
  assign last_row      = (i == ROW_W'(rows - DIM_W'(1)));
  assign row_base_next = row_base + ADDR_W'(inner);

  always_comb begin
    tag.valid     = active;
    tag.first     = ew || (k == '0);
    tag.last_term = last_term;
    tag.run_last  = last_term && last_col && last_row;
    tag.row       = ew ? '0 : i;
    tag.col       = ew ? a_addr : ADDR_W'(j);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active   <= 1'b1;
      rows     <= clamp_dim(dims.rows);
      inner    <= clamp_dim(dims.inner);
      cols     <= clamp_dim(dims.cols);
      ew       <= dims.elementwise;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      a_addr   <= '0;
      b_addr   <= '0;
      row_base <= '0;
    end else if (active && adv) begin
      if (!last_term) begin
        k      <= k + ROW_W'(1);
        a_addr <= a_addr + ADDR_W'(1);
        b_addr <= b_addr + ADDR_W'(cols);
      end else begin
        k <= '0;
        if (!last_col) begin
          j <= j + ROW_W'(1);
          if (ew) begin
            a_addr <= a_addr + ADDR_W'(1);
            b_addr <= b_addr + ADDR_W'(1);
          end else begin
            a_addr <= row_base;
            b_addr <= ADDR_W'(j) + ADDR_W'(1);
          end
        end else begin
          j <= '0;
          if (!last_row) begin
            i <= i + ROW_W'(1);
            if (ew) begin
              a_addr <= a_addr + ADDR_W'(1);
              b_addr <= b_addr + ADDR_W'(1);
            end else begin
              row_base <= row_base_next;
              a_addr   <= row_base_next;
              b_addr   <= '0;
            end
          end else begin
            active <= 1'b0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/smm_mac.sv =====
`default_nettype none

module smm_mac (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire smm_pkg::term_tag_t          tag_in,
  input  wire logic [smm_pkg::VAL_W-1:0]   a_rd,
  input  wire logic [smm_pkg::VAL_W-1:0]   b_rd,
  output logic                             pipe_busy,
  output logic                             out_valid,
  output logic      [smm_pkg::PROD_W-1:0]  out_value,
  output logic      [smm_pkg::ROW_W-1:0]   out_row,
  output logic      [smm_pkg::ADDR_W-1:0]  out_col,
  output logic                             out_last
);
  import smm_pkg::*;

  term_tag_t          t1;
  term_tag_t          t2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic        [PROD_W-1:0] sat;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'({1'b0, {(PROD_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  assign pipe_busy = t1.valid || t2.valid;
  assign acc_next  = (t2.first ? '0 : acc) + ACC_W'(prod);

  always_comb begin
    if (acc_next > SAT_MAX) begin
      sat = SAT_MAX[PROD_W-1:0];
    end else if (acc_next < SAT_MIN) begin
      sat = SAT_MIN[PROD_W-1:0];
    end else begin
      sat = acc_next[PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid  <= 1'b0;
      t2.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      t1        <= tag_in;
      t2        <= t1;
      prod      <= $signed(a_rd) * $signed(b_rd);
      out_valid <= t2.valid && t2.last_term;
      if (t2.valid) begin
        acc <= acc_next;
      end
      if (t2.valid && t2.last_term) begin
        out_value <= sat;
        out_row   <= t2.row;
        out_col   <= t2.col;
        out_last  <= t2.run_last;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/small_matrix_multiply_tb.sv =====
`timescale 1ns / 100ps

module small_matrix_multiply_tb;
  import smm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam longint Q16_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q16_MIN   = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [31:0] product;
    logic [2:0]  row;
    logic [5:0]  col;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic             is_cfg;
    logic [1:0]       reg_idx;
    logic [3:0]       reg_val;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             typed;
    logic [31:0]      typed_product;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  logic [VAL_W-1:0] a_elems [DEPTH];
  logic [VAL_W-1:0] b_elems [DEPTH];
  bit               a_written [DEPTH];
  bit               b_written [DEPTH];
  logic [3:0]       rows_reg = 4'd1;
  logic [3:0]       inner_reg = 4'd1;
  logic [3:0]       cols_reg = 4'd1;
  logic             ew_reg = 1'b0;
  entry_t           expected_entries [$];
  int               gap_pct = 0;
  int               stall_pct = 0;
  logic             rx_hold = 1'b0;
  int               mismatches = 0;
  step_t            directed [34];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  small_matrix_multiply dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int dim_used(logic [3:0] d);
    if (d == 4'd0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic logic [31:0] saturate_q16(longint s);
    if (s > Q16_MAX) return 32'h7FFF_FFFF;
    if (s < Q16_MIN) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic longint elem_product(logic [15:0] a, logic [15:0] b);
    return longint'($signed(a)) * longint'($signed(b));
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] rand_dim();
    int pick;
    pick = $urandom_range(9);
    if (pick < 8) return 4'($urandom_range(1, 4));
    if (pick == 8) return 4'($urandom_range(5, 8));
    return 4'($urandom_range(15));
  endfunction

  function automatic step_t load_step(logic [1:0] c, logic [5:0] i, logic [15:0] v);
    return '{1'b0, 2'd0, 4'd0, c, i, v, 1'b0, 32'h0};
  endfunction

  function automatic step_t compute_step(logic typed, logic [31:0] prod);
    return '{1'b0, 2'd0, 4'd0, CMD_COMPUTE, 6'd0, 16'h0, typed, prod};
  endfunction

  function automatic step_t reg_step(logic [1:0] r, logic [3:0] v);
    return '{1'b1, r, v, CMD_WRITE_A, 6'd0, 16'h0, 1'b0, 32'h0};
  endfunction

  task automatic predict_products();
    int rows, inner, cols, total, n;
    longint acc;
    entry_t e;
    rows  = dim_used(rows_reg);
    inner = dim_used(inner_reg);
    cols  = dim_used(cols_reg);
    total = rows * cols;
    n = 0;
    if (ew_reg) begin
      for (int i = 0; i < total; i++) begin
        e.product = saturate_q16(elem_product(a_elems[i], b_elems[i]));
        e.row = 3'd0;
        e.col = 6'(i);
        e.last = (i == total - 1);
        expected_entries.push_back(e);
      end
    end else begin
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          acc = 0;
          for (int k = 0; k < inner; k++)
            acc += elem_product(a_elems[r * inner + k], b_elems[k * cols + c]);
          n++;
          e.product = saturate_q16(acc);
          e.row = 3'(r);
          e.col = 6'(c);
          e.last = (n == total);
          expected_entries.push_back(e);
        end
      end
    end
  endtask

  task automatic send_word(logic [1:0] cmd, logic [5:0] idx, logic [15:0] val,
                           logic typed, logic [31:0] typed_product);
    entry_t e;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (cmd)
      CMD_WRITE_A: begin
        a_elems[idx] = val;
        a_written[idx] = 1'b1;
      end
      CMD_WRITE_B: begin
        b_elems[idx] = val;
        b_written[idx] = 1'b1;
      end
      CMD_COMPUTE: begin
        if (typed) begin
          e = '{typed_product, 3'd0, 6'd0, 1'b1};
          expected_entries.push_back(e);
        end else begin
          predict_products();
        end
      end
      default: ;
    endcase
  endtask

  // Entries that the run will read are written first, since the stores
  // power up unknown.
  task automatic run_compute(logic typed, logic [31:0] typed_product);
    int rows, inner, cols, a_need, b_need;
    rows  = dim_used(rows_reg);
    inner = dim_used(inner_reg);
    cols  = dim_used(cols_reg);
    a_need = ew_reg ? rows * cols : rows * inner;
    b_need = ew_reg ? rows * cols : inner * cols;
    for (int i = 0; i < a_need; i++)
      if (!a_written[i]) send_word(CMD_WRITE_A, 6'(i), rand_value(), 1'b0, 32'h0);
    for (int i = 0; i < b_need; i++)
      if (!b_written[i]) send_word(CMD_WRITE_B, 6'(i), rand_value(), 1'b0, 32'h0);
    send_word(CMD_COMPUTE, 6'($urandom), 16'($urandom), typed, typed_product);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] r, logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      REG_NUM_ROWS:  rows_reg = v;
      REG_INNER_LEN: inner_reg = v;
      REG_NUM_COLS:  cols_reg = v;
      REG_ELEMWISE:  ew_reg = v[0];
      default: ;
    endcase
  endtask

  task automatic set_dims(logic [3:0] r, logic [3:0] i, logic [3:0] c, logic [3:0] e);
    settle();
    write_reg(REG_NUM_ROWS, r);
    write_reg(REG_INNER_LEN, i);
    write_reg(REG_NUM_COLS, c);
    write_reg(REG_ELEMWISE, e);
  endtask

  always @(posedge clk) begin
    if (rx_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    entry_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_entries.size() == 0) begin
        $error("unexpected result word: product_value %h", m_tdata[31:0]);
        mismatches++;
      end else begin
        want = expected_entries.pop_front();
        if (m_tdata[31:0] !== want.product) begin
          $error("product_value: expected %h, got %h", want.product, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[34:32] !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, m_tdata[34:32]);
          mismatches++;
        end
        if (m_tdata[40:35] !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, m_tdata[40:35]);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int pick, span, m;
    directed = '{
      load_step(CMD_WRITE_A, 6'd0, 16'h7FFF),
      load_step(CMD_WRITE_B, 6'd0, 16'h7FFF),
      compute_step(1'b1, 32'h3FFF_0001),
      load_step(CMD_WRITE_A, 6'd0, 16'h8000),
      load_step(CMD_WRITE_B, 6'd0, 16'h8000),
      compute_step(1'b1, 32'h4000_0000),
      load_step(CMD_WRITE_B, 6'd0, 16'h7FFF),
      compute_step(1'b1, 32'hC000_8000),
      load_step(CMD_UNUSED, 6'd63, 16'hFFFF),
      load_step(CMD_WRITE_B, 6'd63, 16'h0000),
      compute_step(1'b1, 32'hC000_8000),
      reg_step(REG_NUM_ROWS, 4'd0),
      reg_step(REG_INNER_LEN, 4'd0),
      reg_step(REG_NUM_COLS, 4'd0),
      compute_step(1'b1, 32'hC000_8000),
      reg_step(REG_NUM_ROWS, 4'd15),
      reg_step(REG_INNER_LEN, 4'd15),
      reg_step(REG_NUM_COLS, 4'd1),
      reg_step(REG_ELEMWISE, 4'd1),
      compute_step(1'b0, 32'h0),
      reg_step(REG_NUM_ROWS, 4'd1),
      reg_step(REG_INNER_LEN, 4'd3),
      reg_step(REG_NUM_COLS, 4'd1),
      reg_step(REG_ELEMWISE, 4'd0),
      load_step(CMD_WRITE_A, 6'd1, 16'h8000),
      load_step(CMD_WRITE_A, 6'd2, 16'h8000),
      load_step(CMD_WRITE_B, 6'd0, 16'h8000),
      load_step(CMD_WRITE_B, 6'd1, 16'h8000),
      load_step(CMD_WRITE_B, 6'd2, 16'h8000),
      compute_step(1'b1, 32'h7FFF_FFFF),
      load_step(CMD_WRITE_B, 6'd0, 16'h7FFF),
      load_step(CMD_WRITE_B, 6'd1, 16'h7FFF),
      load_step(CMD_WRITE_B, 6'd2, 16'h7FFF),
      compute_step(1'b1, 32'h8000_0000)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[n]) begin
      if (directed[n].is_cfg) begin
        if (n == 0 || !directed[n - 1].is_cfg) settle();
        write_reg(directed[n].reg_idx, directed[n].reg_val);
      end else if (directed[n].cmd == CMD_COMPUTE) begin
        run_compute(directed[n].typed, directed[n].typed_product);
      end else begin
        send_word(directed[n].cmd, directed[n].idx, directed[n].val, 1'b0, 32'h0);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      set_dims(rand_dim(), rand_dim(), rand_dim(), 4'($urandom_range(15)));
      m = dim_used(rows_reg);
      if (dim_used(inner_reg) > m) m = dim_used(inner_reg);
      if (dim_used(cols_reg) > m) m = dim_used(cols_reg);
      span = m * m;
      for (int k = 0; k < 12; k++) begin
        pick = $urandom_range(99);
        if (pick < 18) begin
          run_compute(1'b0, 32'h0);
        end else if (pick < 23) begin
          send_word(CMD_UNUSED, 6'($urandom), 16'($urandom), 1'b0, 32'h0);
        end else begin
          send_word($urandom_range(1) ? CMD_WRITE_B : CMD_WRITE_A,
                    ($urandom_range(9) < 7) ? 6'($urandom_range(span - 1)) : 6'($urandom),
                    rand_value(), 1'b0, 32'h0);
        end
      end
      run_compute(1'b0, 32'h0);
    end

    // The receiver holds off while more words are offered, so the run
    // backs up into the input.
    gap_pct = 0;
    stall_pct = 0;
    set_dims(4'd4, 4'd4, 4'd4, 4'd0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        run_compute(1'b0, 32'h0);
        for (int k = 0; k < 8; k++)
          send_word($urandom_range(1) ? CMD_WRITE_B : CMD_WRITE_A, 6'($urandom),
                    rand_value(), 1'b0, 32'h0);
        run_compute(1'b0, 32'h0);
      end
    join

    settle();
    if (mismatches == 0) begin
      $display("** small_matrix_multiply: PASSED **");
    end else begin
      $display("** small_matrix_multiply: FAILED **");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("** small_matrix_multiply: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/smm_pkg.sv
sv/smm_store.sv
sv/smm_seq.sv
sv/smm_mac.sv
sv/small_matrix_multiply.sv
tb/small_matrix_multiply_tb.sv
